// ===== rtl/utf8_regex_pattern_lexer_defines.svh =====
// Assertion macros for the UTF-8 regex pattern lexer.
`ifndef UTF8_REGEX_PATTERN_LEXER_DEFINES_SVH
`define UTF8_REGEX_PATTERN_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define U8LEX_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("u8lex: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define U8LEX_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("u8lex: next-cycle check failed");

`endif

// ===== rtl/u8lex_pkg.sv =====
// Types, constants and helpers shared by the UTF-8 regex pattern lexer.
`default_nettype none

package u8lex_pkg;

	localparam int unsigned MaxResults = 3;

	typedef enum logic [1:0] {
		LM_IDLE  = 2'd0,
		LM_ESC   = 2'd1,
		LM_ESC_C = 2'd2,
		LM_HEX   = 2'd3
	} lex_mode_t;

	typedef enum logic [1:0] {
		TK_CHAR  = 2'd0,
		TK_CTRL  = 2'd1,
		TK_CLASS = 2'd2,
		TK_END   = 2'd3
	} token_kind_t;

	typedef struct packed {
		lex_mode_t   mode;
		logic [30:0] code_acc;
		logic [2:0]  rem;
		logic [31:0] hex_acc;
		logic        disc;
	} lex_state_t;

	typedef struct packed {
		token_kind_t kind;
		logic [31:0] value;
		logic        status;
		logic        last;
	} token_t;

	localparam lex_state_t StateReset = '{
		mode:     LM_IDLE,
		code_acc: 31'd0,
		rem:      3'd0,
		hex_acc:  32'd0,
		disc:     1'b0
	};

	function automatic token_t mk_tok(token_kind_t kind, logic [31:0] value, logic status);
		token_t t;
		t.kind   = kind;
		t.value  = value;
		t.status = status;
		t.last   = 1'b0;
		return t;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/u8lex_byte_if.sv =====
// Channel carrying pattern bytes into the lexer.
`default_nettype none

interface u8lex_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] pattern_byte;
	logic       final_byte;

	modport source (output valid, output pattern_byte, output final_byte, input ready);
	modport sink (input valid, input pattern_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/u8lex_token_if.sv =====
// Channel carrying lexer tokens out of the lexer.
`default_nettype none

interface u8lex_token_if;
	logic        valid;
	logic        ready;
	logic [1:0]  token_kind;
	logic [31:0] token_value;
	logic        status;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_value, output status,
		output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_value, input status,
		input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/utf8_regex_pattern_lexer.sv =====
// UTF-8 regex pattern lexer: top level with lexer state and token buffer.
//
// Usage:
//   pattern: one raw UTF-8 byte per transaction; final_byte marks the last
//            byte of a pattern.
//   token:   token transactions (kind, value, status, last_of_run). Every
//            byte gives zero to three tokens; the last token of a byte has
//            last_of_run set, and a final byte always ends with an end token
//            whose status flags corrupt UTF-8.
// Output: the first token of a byte appears the cycle after it is taken.
// Throughput: one byte per cycle while each byte gives at most one token
//   and the sink holds ready high; the three-entry token buffer drains one
//   token a cycle while ready is high and takes the next byte in the cycle
//   its last token leaves.
// Reset: arst_n clears the lexer state and empties the token buffer; the
//   block can take a byte as soon as reset is released.
// Stall: while the sink holds ready low the buffered tokens stay put and
//   pattern ready stays low whenever any token is waiting.
`default_nettype none

module utf8_regex_pattern_lexer (
	input  var logic      clk,
	input  var logic      arst_n,
	u8lex_byte_if.sink    pattern,
	u8lex_token_if.source token
);

	`include "utf8_regex_pattern_lexer_defines.svh"

	u8lex_pkg::lex_state_t state_q;
	u8lex_pkg::lex_state_t state_nxt;
	u8lex_pkg::token_t     res_q [u8lex_pkg::MaxResults];
	u8lex_pkg::token_t     res_nxt [u8lex_pkg::MaxResults];
	logic [1:0]            cnt_q;
	logic [1:0]            res_cnt;
	logic                  push;
	logic                  pop;

	u8lex_core u_core (
		.cur          (state_q),
		.pattern_byte (pattern.pattern_byte),
		.final_byte   (pattern.final_byte),
		.nxt          (state_nxt),
		.results      (res_nxt),
		.count        (res_cnt)
	);

	assign pop           = token.valid && token.ready;
	assign pattern.ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && token.ready);
	assign push          = pattern.valid && pattern.ready;

	assign token.valid       = (cnt_q != 2'd0);
	assign token.token_kind  = res_q[0].kind;
	assign token.token_value = res_q[0].value;
	assign token.status      = res_q[0].status;
	assign token.last_of_run = res_q[0].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= u8lex_pkg::StateReset;
			cnt_q   <= 2'd0;
		end else if (push) begin
			state_q <= state_nxt;
			cnt_q   <= res_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q <= res_nxt;
		end else if (pop) begin
			res_q[0] <= res_q[1];
			res_q[1] <= res_q[2];
		end
	end

	`U8LEX_ASSERT_NEXT(a_final_resets, push && pattern.final_byte, state_q == u8lex_pkg::StateReset)
	`U8LEX_ASSERT_NEXT(a_discard_silent, push && state_q.disc && !pattern.final_byte, cnt_q == 2'd0)
	`U8LEX_ASSERT_IMPL(a_tail_is_last, cnt_q == 2'd1, res_q[0].last)

endmodule

`default_nettype wire

// ===== rtl/u8lex_core.sv =====
// Next-state and token logic for one pattern byte: UTF-8 assembly and lexing.
`default_nettype none

module u8lex_core (
	input  var u8lex_pkg::lex_state_t cur,
	input  var logic [7:0]            pattern_byte,
	input  var logic                  final_byte,
	output u8lex_pkg::lex_state_t     nxt,
	output u8lex_pkg::token_t         results [u8lex_pkg::MaxResults],
	output logic [1:0]                count
);

	localparam logic [7:0] ChBslash = 8'h5c;

	function automatic logic is_meta(logic [7:0] c);
		return c == 8'h28 || c == 8'h7c || c == 8'h29 || c == 8'h5b || c == 8'h5d ||
			c == 8'h7b || c == 8'h7d || c == 8'h2c || c == 8'h3f || c == 8'h2a ||
			c == 8'h2b;
	endfunction

	logic [30:0] cp;
	logic        is_byte;
	logic [7:0]  low;
	logic        complete;
	logic        bad;
	logic        is_dec;
	logic        is_hex;
	logic [3:0]  hval;
	logic        prior_hex;
	logic        is_ctl;

	always_comb begin
		nxt       = cur;
		count     = 2'd0;
		complete  = 1'b0;
		bad       = 1'b0;
		cp        = 31'd0;
		is_byte   = 1'b0;
		low       = 8'd0;
		is_dec    = 1'b0;
		is_hex    = 1'b0;
		hval      = 4'd0;
		is_ctl    = 1'b0;
		prior_hex = (cur.mode == u8lex_pkg::LM_HEX);
		for (int i = 0; i < u8lex_pkg::MaxResults; i++) begin
			results[i] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CHAR, 32'd0, 1'b0);
		end
		if (!cur.disc) begin
			if (cur.rem == 3'd0) begin
				priority if (!pattern_byte[7]) begin
					nxt.code_acc = {24'd0, pattern_byte[6:0]};
					complete = 1'b1;
				end else if (!pattern_byte[6]) begin
					bad = 1'b1;
				end else if (!pattern_byte[5]) begin
					nxt.code_acc = {26'd0, pattern_byte[4:0]};
					nxt.rem = 3'd1;
				end else if (!pattern_byte[4]) begin
					nxt.code_acc = {27'd0, pattern_byte[3:0]};
					nxt.rem = 3'd2;
				end else if (!pattern_byte[3]) begin
					nxt.code_acc = {28'd0, pattern_byte[2:0]};
					nxt.rem = 3'd3;
				end else if (!pattern_byte[2]) begin
					nxt.code_acc = {29'd0, pattern_byte[1:0]};
					nxt.rem = 3'd4;
				end else if (!pattern_byte[1]) begin
					nxt.code_acc = {30'd0, pattern_byte[0]};
					nxt.rem = 3'd5;
				end else begin
					bad = 1'b1;
				end
			end else if (pattern_byte[7:6] != 2'b10) begin
				bad = 1'b1;
			end else begin
				nxt.code_acc = {cur.code_acc[24:0], pattern_byte[5:0]};
				nxt.rem = cur.rem - 3'd1;
				complete = (cur.rem == 3'd1);
			end
			cp      = nxt.code_acc;
			is_byte = (cp[30:8] == 23'd0);
			low     = cp[7:0];
			is_dec  = is_byte && low >= 8'h30 && low <= 8'h39;
			is_hex  = is_dec || (is_byte && ((low >= 8'h61 && low <= 8'h66) ||
				(low >= 8'h41 && low <= 8'h46)));
			hval    = is_dec ? low[3:0] : low[3:0] + 4'd9;
			is_ctl  = is_byte && ((low >= 8'h61 && low <= 8'h7a) ||
				(low >= 8'h41 && low <= 8'h5f));
			if (bad) begin
				nxt.disc = 1'b1;
			end
			if (complete) begin
				unique case (cur.mode)
					u8lex_pkg::LM_IDLE: begin
						if (is_byte && low == ChBslash) begin
							nxt.mode = u8lex_pkg::LM_ESC;
						end else begin
							results[count] = u8lex_pkg::mk_tok((is_byte && is_meta(low)) ?
								u8lex_pkg::TK_CTRL : u8lex_pkg::TK_CHAR, {1'b0, cp}, 1'b0);
							count = count + 2'd1;
						end
					end
					u8lex_pkg::LM_ESC: begin
						nxt.mode = u8lex_pkg::LM_IDLE;
						unique case ({!is_byte, low})
							9'h063: nxt.mode = u8lex_pkg::LM_ESC_C;
							9'h078, 9'h075: begin
								nxt.mode = u8lex_pkg::LM_HEX;
								nxt.hex_acc = 32'd0;
							end
							9'h064: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd0, 1'b0);
								count = count + 2'd1;
							end
							9'h044: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd1, 1'b0);
								count = count + 2'd1;
							end
							9'h066: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd2, 1'b0);
								count = count + 2'd1;
							end
							9'h06e: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd3, 1'b0);
								count = count + 2'd1;
							end
							9'h072: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd4, 1'b0);
								count = count + 2'd1;
							end
							9'h073: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd5, 1'b0);
								count = count + 2'd1;
							end
							9'h053: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd6, 1'b0);
								count = count + 2'd1;
							end
							9'h074: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd7, 1'b0);
								count = count + 2'd1;
							end
							9'h076: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd8, 1'b0);
								count = count + 2'd1;
							end
							9'h077: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd9, 1'b0);
								count = count + 2'd1;
							end
							9'h057: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CLASS, 32'd10, 1'b0);
								count = count + 2'd1;
							end
							default: begin
								results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CHAR, {1'b0, cp}, 1'b0);
								count = count + 2'd1;
							end
						endcase
					end
					u8lex_pkg::LM_ESC_C: begin
						results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CHAR,
							is_ctl ? {27'd0, low[4:0]} : {1'b0, cp}, 1'b0);
						count = count + 2'd1;
						nxt.mode = u8lex_pkg::LM_IDLE;
					end
					u8lex_pkg::LM_HEX: begin
						if (is_hex) begin
							nxt.hex_acc = {cur.hex_acc[27:0], hval};
						end else begin
							results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CHAR, cur.hex_acc, 1'b0);
							count = count + 2'd1;
							nxt.mode = u8lex_pkg::LM_IDLE;
							if (is_byte && low == ChBslash) begin
								nxt.mode = u8lex_pkg::LM_ESC;
							end else begin
								results[count] = u8lex_pkg::mk_tok((is_byte && is_meta(low)) ?
									u8lex_pkg::TK_CTRL : u8lex_pkg::TK_CHAR, {1'b0, cp}, 1'b0);
								count = count + 2'd1;
							end
						end
					end
					default: nxt.mode = u8lex_pkg::LM_IDLE;
				endcase
				if (final_byte && prior_hex && nxt.mode == u8lex_pkg::LM_HEX) begin
					results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_CHAR, nxt.hex_acc, 1'b0);
					count = count + 2'd1;
					nxt.mode = u8lex_pkg::LM_IDLE;
				end
			end
			if (final_byte && !nxt.disc && nxt.rem != 3'd0) begin
				nxt.disc = 1'b1;
			end
		end
		if (final_byte) begin
			results[count] = u8lex_pkg::mk_tok(u8lex_pkg::TK_END, 32'd0, nxt.disc);
			count = count + 2'd1;
			nxt = u8lex_pkg::StateReset;
		end
		if (count != 2'd0) begin
			results[count - 2'd1].last = 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== bench/tb_utf8_regex_pattern_lexer.sv =====
// Self-checking testbench for the UTF-8 regex pattern lexer: directed and random patterns.
module tb_utf8_regex_pattern_lexer;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 100000;
	localparam int RandomByteTarget = 205;

	typedef enum logic [31:0] {
		CLS_DIGIT     = 32'd0,
		CLS_NOT_DIGIT = 32'd1,
		CLS_FORMFEED  = 32'd2,
		CLS_NEWLINE   = 32'd3,
		CLS_RETURN    = 32'd4,
		CLS_SPACE     = 32'd5,
		CLS_NOT_SPACE = 32'd6,
		CLS_TAB       = 32'd7,
		CLS_VTAB      = 32'd8,
		CLS_WORD      = 32'd9,
		CLS_NOT_WORD  = 32'd10
	} class_code_t;

	logic clk;
	logic arst_n;

	u8lex_byte_if  pattern_ch ();
	u8lex_token_if token_ch ();

	utf8_regex_pattern_lexer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pattern(pattern_ch),
		.token  (token_ch)
	);

	u8lex_pkg::lex_state_t lexer;
	u8lex_pkg::token_t     byte_tokens[$];
	u8lex_pkg::token_t     pending_tokens[$];
	u8lex_pkg::token_t     oldest_token;
	logic [7:0]  pattern_bytes[$];
	bit          steady;
	int          mismatches;
	int          cycle_count;
	int          random_bytes_sent;
	string       lit_chars = "\\()|[]{},?*+cxudDfnrsStvwW0aF9gzZ_^.$";
	string       class_letters = "dDfnrsStvwW";
	string       ctrl_letters = "aAzZmQ[\\]^_@{";
	string       hex_chars = "0123456789abcdefABCDEF";

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(negedge clk)
		token_ch.ready <= steady || ($urandom_range(99) >= 20);

	always @(posedge clk) begin
		if (arst_n && token_ch.valid && token_ch.ready) begin
			if (pending_tokens.size() == 0) begin
				$error("unexpected token: kind %0d value %0h", token_ch.token_kind,
					token_ch.token_value);
				mismatches++;
			end else begin
				oldest_token = pending_tokens.pop_front();
				if (token_ch.token_kind !== oldest_token.kind) begin
					$error("token_kind: expected %0d, got %0d", oldest_token.kind,
						token_ch.token_kind);
					mismatches++;
				end
				if (token_ch.token_value !== oldest_token.value) begin
					$error("token_value: expected %0h, got %0h", oldest_token.value,
						token_ch.token_value);
					mismatches++;
				end
				if (token_ch.status !== oldest_token.status) begin
					$error("status: expected %0d, got %0d", oldest_token.status,
						token_ch.status);
					mismatches++;
				end
				if (token_ch.last_of_run !== oldest_token.last) begin
					$error("last_of_run: expected %0d, got %0d", oldest_token.last,
						token_ch.last_of_run);
					mismatches++;
				end
			end
		end
	end

	task automatic add_token(input u8lex_pkg::token_kind_t kind, input logic [31:0] value,
		input logic status);
		u8lex_pkg::token_t t;
		t.kind   = kind;
		t.value  = value;
		t.status = status;
		t.last   = 1'b0;
		if (byte_tokens.size() < u8lex_pkg::MaxResults)
			byte_tokens.push_back(t);
	endtask

	function automatic logic hex_nibble(input logic [30:0] cp, output logic [3:0] nib);
		nib = 4'd0;
		if (cp >= "0" && cp <= "9") begin
			nib = 4'(cp - "0");
			return 1'b1;
		end
		if (cp >= "a" && cp <= "f") begin
			nib = 4'(cp - "a" + 10);
			return 1'b1;
		end
		if (cp >= "A" && cp <= "F") begin
			nib = 4'(cp - "A" + 10);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic lex_plain(input logic [30:0] cp);
		case (cp)
			"\\": lexer.mode = u8lex_pkg::LM_ESC;
			"(", "|", ")", "[", "]", "{", "}", ",", "?", "*", "+":
				add_token(u8lex_pkg::TK_CTRL, {1'b0, cp}, 1'b0);
			default: add_token(u8lex_pkg::TK_CHAR, {1'b0, cp}, 1'b0);
		endcase
	endtask

	task automatic lex_code_point(input logic [30:0] cp);
		logic [31:0] v;
		logic [3:0]  nib;
		case (lexer.mode)
			u8lex_pkg::LM_IDLE: lex_plain(cp);
			u8lex_pkg::LM_ESC: begin
				lexer.mode = u8lex_pkg::LM_IDLE;
				case (cp)
					"c": lexer.mode = u8lex_pkg::LM_ESC_C;
					"x", "u": begin
						lexer.mode    = u8lex_pkg::LM_HEX;
						lexer.hex_acc = 32'd0;
					end
					"d": add_token(u8lex_pkg::TK_CLASS, CLS_DIGIT, 1'b0);
					"D": add_token(u8lex_pkg::TK_CLASS, CLS_NOT_DIGIT, 1'b0);
					"f": add_token(u8lex_pkg::TK_CLASS, CLS_FORMFEED, 1'b0);
					"n": add_token(u8lex_pkg::TK_CLASS, CLS_NEWLINE, 1'b0);
					"r": add_token(u8lex_pkg::TK_CLASS, CLS_RETURN, 1'b0);
					"s": add_token(u8lex_pkg::TK_CLASS, CLS_SPACE, 1'b0);
					"S": add_token(u8lex_pkg::TK_CLASS, CLS_NOT_SPACE, 1'b0);
					"t": add_token(u8lex_pkg::TK_CLASS, CLS_TAB, 1'b0);
					"v": add_token(u8lex_pkg::TK_CLASS, CLS_VTAB, 1'b0);
					"w": add_token(u8lex_pkg::TK_CLASS, CLS_WORD, 1'b0);
					"W": add_token(u8lex_pkg::TK_CLASS, CLS_NOT_WORD, 1'b0);
					default: add_token(u8lex_pkg::TK_CHAR, {1'b0, cp}, 1'b0);
				endcase
			end
			u8lex_pkg::LM_ESC_C: begin
				v = {1'b0, cp};
				if (cp >= "a" && cp <= "z")
					v = {1'b0, cp} - 32'("a") + 32'd1;
				else if (cp >= "A" && cp <= "Z")
					v = {1'b0, cp} - 32'("A") + 32'd1;
				else if (cp == "[")
					v = 32'd27;
				else if (cp == "\\")
					v = 32'd28;
				else if (cp == "]")
					v = 32'd29;
				else if (cp == "^")
					v = 32'd30;
				else if (cp == "_")
					v = 32'd31;
				add_token(u8lex_pkg::TK_CHAR, v, 1'b0);
				lexer.mode = u8lex_pkg::LM_IDLE;
			end
			default: begin
				if (hex_nibble(cp, nib)) begin
					lexer.hex_acc = {lexer.hex_acc[27:0], nib};
				end else begin
					add_token(u8lex_pkg::TK_CHAR, lexer.hex_acc, 1'b0);
					lexer.mode = u8lex_pkg::LM_IDLE;
					lex_plain(cp);
				end
			end
		endcase
	endtask

	task automatic predict_tokens(input logic [7:0] b, input logic fin);
		logic                 done;
		logic                 bad;
		u8lex_pkg::lex_mode_t prior;
		byte_tokens.delete();
		done = 1'b0;
		bad  = 1'b0;
		if (!lexer.disc) begin
			if (lexer.rem == 3'd0) begin
				if (b < 8'h80) begin
					lexer.code_acc = {24'd0, b[6:0]};
					done = 1'b1;
				end else if (b < 8'hC0) begin
					bad = 1'b1;
				end else if (b < 8'hE0) begin
					lexer.code_acc = {26'd0, b[4:0]};
					lexer.rem = 3'd1;
				end else if (b < 8'hF0) begin
					lexer.code_acc = {27'd0, b[3:0]};
					lexer.rem = 3'd2;
				end else if (b < 8'hF8) begin
					lexer.code_acc = {28'd0, b[2:0]};
					lexer.rem = 3'd3;
				end else if (b < 8'hFC) begin
					lexer.code_acc = {29'd0, b[1:0]};
					lexer.rem = 3'd4;
				end else if (b < 8'hFE) begin
					lexer.code_acc = {30'd0, b[0]};
					lexer.rem = 3'd5;
				end else begin
					bad = 1'b1;
				end
			end else if (b[7:6] != 2'b10) begin
				bad = 1'b1;
			end else begin
				lexer.code_acc = {lexer.code_acc[24:0], b[5:0]};
				lexer.rem = lexer.rem - 3'd1;
				if (lexer.rem == 3'd0)
					done = 1'b1;
			end
			if (bad)
				lexer.disc = 1'b1;
			if (done) begin
				prior = lexer.mode;
				lex_code_point(lexer.code_acc);
				if (fin && prior == u8lex_pkg::LM_HEX && lexer.mode == u8lex_pkg::LM_HEX) begin
					add_token(u8lex_pkg::TK_CHAR, lexer.hex_acc, 1'b0);
					lexer.mode = u8lex_pkg::LM_IDLE;
				end
			end
			if (fin && !lexer.disc && lexer.rem != 3'd0)
				lexer.disc = 1'b1;
		end
		if (fin) begin
			add_token(u8lex_pkg::TK_END, 32'd0, lexer.disc);
			lexer = u8lex_pkg::StateReset;
		end
		if (byte_tokens.size() > 0)
			byte_tokens[byte_tokens.size() - 1].last = 1'b1;
		foreach (byte_tokens[i])
			pending_tokens.push_back(byte_tokens[i]);
	endtask

	function automatic bit idle_now();
		return !steady && ($urandom_range(99) < 20);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while (idle_now()) begin
			pattern_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pattern_ch.valid        <= 1'b1;
		pattern_ch.pattern_byte <= b;
		pattern_ch.final_byte   <= fin;
		do
			@(posedge clk);
		while (!pattern_ch.ready);
		predict_tokens(b, fin);
		@(negedge clk);
	endtask

	task automatic send_pattern();
		foreach (pattern_bytes[i])
			send_byte(pattern_bytes[i], i == pattern_bytes.size() - 1);
		pattern_bytes.delete();
	endtask

	task automatic put_code_point(input logic [30:0] cp, input int nbytes);
		logic [7:0] lead_prefix;
		logic [7:0] lead_mask;
		case (nbytes)
			2: begin lead_prefix = 8'hC0; lead_mask = 8'h1F; end
			3: begin lead_prefix = 8'hE0; lead_mask = 8'h0F; end
			4: begin lead_prefix = 8'hF0; lead_mask = 8'h07; end
			5: begin lead_prefix = 8'hF8; lead_mask = 8'h03; end
			6: begin lead_prefix = 8'hFC; lead_mask = 8'h01; end
			default: begin lead_prefix = 8'h00; lead_mask = 8'h7F; end
		endcase
		pattern_bytes.push_back(lead_prefix | (8'(cp >> (6 * (nbytes - 1))) & lead_mask));
		for (int i = nbytes - 2; i >= 0; i--)
			pattern_bytes.push_back(8'h80 | (8'(cp >> (6 * i)) & 8'h3F));
	endtask

	function automatic logic [7:0] pick(input string s);
		return s[$urandom_range(s.len() - 1)];
	endfunction

	task automatic put_random_element();
		int n;
		case ($urandom_range(11))
			0, 1: pattern_bytes.push_back(pick(lit_chars));
			2: pattern_bytes.push_back(8'($urandom_range(127)));
			3: put_code_point(31'($urandom), ($urandom_range(3) == 0) ? $urandom_range(4, 6) :
				$urandom_range(2, 3));
			4: begin
				pattern_bytes.push_back("\\");
				pattern_bytes.push_back(pick(class_letters));
			end
			5: begin
				pattern_bytes.push_back("\\");
				pattern_bytes.push_back("c");
				if ($urandom_range(4) == 0)
					put_code_point(31'($urandom), $urandom_range(1, 3));
				else
					pattern_bytes.push_back(pick(ctrl_letters));
			end
			6, 7, 8: begin
				pattern_bytes.push_back("\\");
				pattern_bytes.push_back($urandom_range(1) ? "x" : "u");
				n = ($urandom_range(5) == 0) ? $urandom_range(8, 10) : $urandom_range(0, 4);
				repeat (n) pattern_bytes.push_back(pick(hex_chars));
				if ($urandom_range(1))
					pattern_bytes.push_back(pick(lit_chars));
			end
			9: begin
				pattern_bytes.push_back("\\");
				pattern_bytes.push_back(pick(lit_chars));
			end
			10: put_code_point(31'($urandom), 1);
			default: pattern_bytes.push_back(8'($urandom_range(255)));
		endcase
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pattern_bytes.push_back(s[i]);
	endtask

	task automatic test_escapes();
		put_text("\\cA");
		send_pattern();
		put_text("\\x1f(");
		send_pattern();
		put_text("\\u7F");
		send_pattern();
		put_text("\\");
		send_pattern();
	endtask

	task automatic test_utf8_faults();
		pattern_bytes.push_back(8'h80);
		put_text("a");
		send_pattern();
		pattern_bytes.push_back(8'hC3);
		put_text("A");
		send_pattern();
		pattern_bytes.push_back(8'hE2);
		pattern_bytes.push_back(8'h82);
		send_pattern();
		pattern_bytes.push_back(8'hFF);
		send_pattern();
	endtask

	task automatic test_extremes();
		pattern_bytes.push_back(8'h00);
		send_pattern();
		put_code_point(31'h7FFF_FFFF, 6);
		send_pattern();
	endtask

	task automatic test_random_patterns();
		int pattern_count;
		pattern_count = 0;
		while (random_bytes_sent < RandomByteTarget) begin
			steady = (pattern_count >= 10 && pattern_count < 18);
			repeat ($urandom_range(1, 6)) put_random_element();
			if ($urandom_range(9) == 0 && pattern_bytes.size() > 1)
				void'(pattern_bytes.pop_back());
			random_bytes_sent += pattern_bytes.size();
			send_pattern();
			pattern_count++;
		end
		steady = 1'b0;
	endtask

	task automatic finish_run();
		pattern_ch.valid <= 1'b0;
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending_tokens.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	endtask

	initial begin
		clk                     = 1'b0;
		arst_n                  = 1'b0;
		pattern_ch.valid        = 1'b0;
		pattern_ch.pattern_byte = 8'h00;
		pattern_ch.final_byte   = 1'b0;
		token_ch.ready          = 1'b0;
		lexer                   = u8lex_pkg::StateReset;
		steady                  = 1'b0;
		mismatches              = 0;
		cycle_count             = 0;
		random_bytes_sent       = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_escapes();
		test_utf8_faults();
		test_extremes();
		test_random_patterns();
		finish_run();
	end

endmodule
